FILE: src/panel_input_debounce_and_rotary_decode_macros.svh
// assertion macros for the panel input debounce and rotary decode block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PANEL_INPUT_DEBOUNCE_AND_ROTARY_DECODE_MACROS_SVH
`define PANEL_INPUT_DEBOUNCE_AND_ROTARY_DECODE_MACROS_SVH

// same-cycle implication
`define PIDRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIDRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pidrd_pkg.sv
// types and constants shared by the panel debounce and rotary decode modules
// no dependencies
`default_nettype none

package pidrd_pkg;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned MsW        = 16;
  localparam int unsigned BtnW       = 6;
  localparam int unsigned InnerW     = 4;
  localparam int unsigned ToggleW    = 4;
  localparam int unsigned RotW       = 7;
  localparam int unsigned PosW       = 3;
  localparam int unsigned GroupMax   = 8;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [PosW-1:0] PosInvalid      = 3'd7;
  localparam logic [MsW-1:0]  DebounceReset   = 16'd20;
  localparam logic [MsW-1:0]  RotFaultReset   = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE_MS  = 2'd0,
    CFG_ROT_ALARM_MS = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    REQ_POLL = 1'b0,
    REQ_SEED = 1'b1
  } req_type_e;

  // per-beat control from the pipeline to the state units
  typedef struct packed {
    logic step;
    logic seed;
  } pidrd_ctl_t;

endpackage

`default_nettype wire

FILE: src/pidrd_debounce.sv
// bank of per-line switch debouncers with dwell timers
// depends on pidrd_pkg
`default_nettype none

module pidrd_debounce #(
  parameter int unsigned Lines = 15
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire pidrd_pkg::pidrd_ctl_t  ctl_i,
  input  wire [Lines-1:0]             raw_i,
  input  wire [pidrd_pkg::TimeW-1:0]  now_i,
  input  wire [pidrd_pkg::MsW-1:0]    debounce_ms_i,
  output logic [Lines-1:0]            stable_o
);
  import pidrd_pkg::*;

  logic [Lines-1:0] stable_q, stable_d;
  logic [Lines-1:0] cand_q, cand_d;
  logic [TimeW-1:0] chg_time_q [Lines];
  logic [TimeW-1:0] chg_time_d [Lines];
  logic [TimeW-1:0] elapsed    [Lines];

  always_comb begin
    stable_d = stable_q;
    cand_d   = cand_q;
    for (int k = 0; k < int'(Lines); k++) begin
      chg_time_d[k] = chg_time_q[k];
      elapsed[k]    = now_i - chg_time_q[k];
      if (ctl_i.seed) begin
        stable_d[k]   = raw_i[k];
        cand_d[k]     = raw_i[k];
        chg_time_d[k] = '0;
      end else if (cand_q[k] != raw_i[k]) begin
        // change restarts the dwell
        cand_d[k]     = raw_i[k];
        chg_time_d[k] = now_i;
      end else if (stable_q[k] != raw_i[k] &&
                   elapsed[k] >= TimeW'(debounce_ms_i)) begin
        stable_d[k] = raw_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      cand_q   <= '0;
      for (int k = 0; k < int'(Lines); k++) chg_time_q[k] <= '0;
    end else if (ctl_i.step) begin
      stable_q <= stable_d;
      cand_q   <= cand_d;
      for (int k = 0; k < int'(Lines); k++) chg_time_q[k] <= chg_time_d[k];
    end
  end

  assign stable_o = stable_q;

endmodule

`default_nettype wire

FILE: src/pidrd_rotary.sv
// rotary switch position decoder with timed fault detection
// depends on pidrd_pkg
`default_nettype none

module pidrd_rotary #(
  parameter int unsigned Positions = 7
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire pidrd_pkg::pidrd_ctl_t  ctl_i,
  input  wire [pidrd_pkg::RotW-1:0]   lines_i,
  input  wire [pidrd_pkg::TimeW-1:0]  now_i,
  input  wire [pidrd_pkg::MsW-1:0]    fault_ms_i,
  output logic [pidrd_pkg::PosW-1:0]  position_o,
  output logic                        fault_o
);
  import pidrd_pkg::*;

  localparam logic [RotW-1:0] UsedMask = RotW'((1 << Positions) - 1);

  logic [PosW-1:0]  pos_q, pos_d;
  logic             bad_q, bad_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             fault_q, fault_d;

  logic [RotW-1:0]  used;
  logic [PosW-1:0]  idx;
  logic             single, pair, good;
  logic [TimeW-1:0] elapsed;

  always_comb begin
    used = lines_i & UsedMask;
    idx  = '0;
    pair = 1'b0;
    for (int k = 0; k < int'(Positions); k++) begin
      if (used[k]) idx = idx | PosW'(k);
    end
    for (int k = 0; k + 1 < int'(Positions); k++) begin
      if (used == RotW'(3 << k)) pair = 1'b1;
    end
    single = $onehot(used);
    good   = single || pair;

    pos_d   = pos_q;
    fault_d = fault_q;
    bad_d   = !good;
    start_d = (!good && !bad_q) ? now_i : start_q;
    if (single) pos_d = idx;
    elapsed = now_i - start_d;
    if (bad_d && elapsed >= TimeW'(fault_ms_i)) begin
      fault_d = 1'b1;
      pos_d   = PosInvalid;
    end else if (!bad_d) begin
      fault_d = 1'b0;
    end
  end

  // a seed beat leaves the decoder untouched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosInvalid;
      bad_q   <= 1'b0;
      start_q <= '0;
      fault_q <= 1'b0;
    end else if (ctl_i.step && !ctl_i.seed) begin
      pos_q   <= pos_d;
      bad_q   <= bad_d;
      start_q <= start_d;
      fault_q <= fault_d;
    end
  end

  assign position_o = pos_q;
  assign fault_o    = fault_q;

endmodule

`default_nettype wire

FILE: src/panel_input_debounce_and_rotary_decode.sv
// throughput: a beat waits in the input register while the result is stalled,
// else one beat per cycle; the per-line debounce compares and the rotary
// decode form a single pass between the input register and the state registers
// reset: levels cleared, rotary position invalid (7), alarm cleared,
// debounce time 20 ms and rotary alarm time 100 ms
`default_nettype none
`include "panel_input_debounce_and_rotary_decode_macros.svh"

module panel_input_debounce_and_rotary_decode #(
  parameter int unsigned FRONT_BUTTONS    = 6,
  parameter int unsigned INNER_BUTTONS    = 4,
  parameter int unsigned TOGGLES          = 4,
  parameter int unsigned ROTARY_POSITIONS = 7
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // config write channel
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [pidrd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [pidrd_pkg::MsW-1:0]      cfg_data_i,
  // input channel
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire                           req_type_i,
  input  wire [pidrd_pkg::TimeW-1:0]    now_ms_i,
  input  wire                           enc_button_raw_i,
  input  wire [pidrd_pkg::BtnW-1:0]     buttons_raw_i,
  input  wire [pidrd_pkg::InnerW-1:0]   inner_buttons_raw_i,
  input  wire [pidrd_pkg::ToggleW-1:0]  toggles_raw_i,
  input  wire [pidrd_pkg::RotW-1:0]     rotary_lines_i,
  // result channel
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic                          enc_button_level_o,
  output logic [pidrd_pkg::BtnW-1:0]    button_levels_o,
  output logic [pidrd_pkg::InnerW-1:0]  inner_button_levels_o,
  output logic [pidrd_pkg::ToggleW-1:0] toggle_levels_o,
  output logic [pidrd_pkg::PosW-1:0]    rotary_position_o,
  output logic                          rotary_alarm_o,
  output logic [pidrd_pkg::RotW-1:0]    rotary_echo_o
);
  import pidrd_pkg::*;

  localparam int unsigned OfsFront  = 1;
  localparam int unsigned OfsInner  = 1 + FRONT_BUTTONS;
  localparam int unsigned OfsToggle = 1 + FRONT_BUTTONS + INNER_BUTTONS;
  localparam int unsigned Lines     = 1 + FRONT_BUTTONS + INNER_BUTTONS + TOGGLES;

  // configuration registers
  logic [MsW-1:0] debounce_ms_q, rot_fault_ms_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q  <= DebounceReset;
      rot_fault_ms_q <= RotFaultReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_DEBOUNCE_MS:  debounce_ms_q  <= cfg_data_i;
        CFG_ROT_ALARM_MS: rot_fault_ms_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic              in_valid_q;
  logic              req_type_q;
  logic [TimeW-1:0]  now_q;
  logic              enc_q;
  logic [BtnW-1:0]   btn_q;
  logic [InnerW-1:0] inner_q;
  logic [ToggleW-1:0] tog_q;
  logic [RotW-1:0]   rot_q;

  logic out_valid_q, out_valid_d;
  logic in_accept, fire;

  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_type_q <= req_type_i;
      now_q      <= now_ms_i;
      enc_q      <= enc_button_raw_i;
      btn_q      <= buttons_raw_i;
      inner_q    <= inner_buttons_raw_i;
      tog_q      <= toggles_raw_i;
      rot_q      <= rotary_lines_i;
    end
  end

  // pack the switch lines, bits past a group's count are dropped
  logic [GroupMax-1:0] btn_ext, inner_ext, tog_ext;
  logic [Lines-1:0]    raw_lines;

  always_comb begin
    btn_ext   = GroupMax'(btn_q);
    inner_ext = GroupMax'(inner_q);
    tog_ext   = GroupMax'(tog_q);
    raw_lines = '0;
    raw_lines[0] = enc_q;
    raw_lines[OfsFront  +: FRONT_BUTTONS] = btn_ext[FRONT_BUTTONS-1:0];
    raw_lines[OfsInner  +: INNER_BUTTONS] = inner_ext[INNER_BUTTONS-1:0];
    raw_lines[OfsToggle +: TOGGLES]       = tog_ext[TOGGLES-1:0];
  end

  pidrd_ctl_t ctl;
  assign ctl.step = fire;
  assign ctl.seed = (req_type_e'(req_type_q) == REQ_SEED);

  logic [Lines-1:0] stable;

  pidrd_debounce #(
    .Lines (Lines)
  ) u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .raw_i         (raw_lines),
    .now_i         (now_q),
    .debounce_ms_i (debounce_ms_q),
    .stable_o      (stable)
  );

  pidrd_rotary #(
    .Positions (ROTARY_POSITIONS)
  ) u_rotary (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .lines_i    (rot_q),
    .now_i      (now_q),
    .fault_ms_i (rot_fault_ms_q),
    .position_o (rotary_position_o),
    .fault_o    (rotary_alarm_o)
  );

  // result register: the state units hold levels, position and fault,
  // only the echo needs its own copy
  logic [RotW-1:0] echo_q;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) echo_q <= rot_q;
  end

  logic [GroupMax-1:0] btn_lvl, inner_lvl, tog_lvl;

  assign btn_lvl   = GroupMax'(stable[OfsFront  +: FRONT_BUTTONS]);
  assign inner_lvl = GroupMax'(stable[OfsInner  +: INNER_BUTTONS]);
  assign tog_lvl   = GroupMax'(stable[OfsToggle +: TOGGLES]);

  assign out_valid_o           = out_valid_q;
  assign enc_button_level_o    = stable[0];
  assign button_levels_o       = btn_lvl[BtnW-1:0];
  assign inner_button_levels_o = inner_lvl[InnerW-1:0];
  assign toggle_levels_o       = tog_lvl[ToggleW-1:0];
  assign rotary_echo_o         = echo_q;

  `PIDRD_ASSERT_NOW(a_fault_forces_invalid, rotary_alarm_o,
                    rotary_position_o == PosInvalid,
                    "rotary fault without invalid position")
  `PIDRD_ASSERT_NOW(a_stall_only_when_blocked, in_stall_o,
                    out_valid_o && out_stall_i && in_valid_q,
                    "input stalled while result path is free")
  `PIDRD_ASSERT_NEXT(a_result_drains, out_valid_o && !out_stall_i && !fire,
                     !out_valid_o,
                     "taken result beat still shown")

endmodule

`default_nettype wire

FILE: bench/tb_panel_input_debounce_and_rotary_decode.sv
// testbench for panel_input_debounce_and_rotary_decode: directed and random polls checked
// beat by beat against a behavioral model of the debouncers and the rotary decoder
// depends on pidrd_pkg and the block itself
`default_nettype none

module tb_panel_input_debounce_and_rotary_decode;
  import pidrd_pkg::*;

  localparam int LineCount = 1 + BtnW + InnerW + ToggleW;
  localparam int CycleLimit = 400000;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef struct {
    req_type_e          req;
    logic [TimeW-1:0]   now;
    logic               enc;
    logic [BtnW-1:0]    btn;
    logic [InnerW-1:0]  inner;
    logic [ToggleW-1:0] tog;
    logic [RotW-1:0]    rot;
  } panel_poll_t;

  typedef struct packed {
    logic               enc;
    logic [BtnW-1:0]    btn;
    logic [InnerW-1:0]  inner;
    logic [ToggleW-1:0] tog;
    logic [PosW-1:0]    pos;
    logic               fault;
    logic [RotW-1:0]    echo;
  } panel_report_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [MsW-1:0]       cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 req_type = 1'b0;
  logic [TimeW-1:0]     now_ms = '0;
  logic                 enc_raw = 1'b0;
  logic [BtnW-1:0]      btn_raw = '0;
  logic [InnerW-1:0]    inner_raw = '0;
  logic [ToggleW-1:0]   tog_raw = '0;
  logic [RotW-1:0]      rot_raw = '0;
  logic                 out_stall = 1'b0;

  wire                  cfg_ready;
  wire                  in_stall;
  wire                  out_valid;
  wire                  enc_level;
  wire [BtnW-1:0]       btn_levels;
  wire [InnerW-1:0]     inner_levels;
  wire [ToggleW-1:0]    tog_levels;
  wire [PosW-1:0]       rot_pos;
  wire                  rot_fault;
  wire [RotW-1:0]       rot_echo;

  panel_input_debounce_and_rotary_decode dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_n),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .req_type_i            (req_type),
    .now_ms_i              (now_ms),
    .enc_button_raw_i      (enc_raw),
    .buttons_raw_i         (btn_raw),
    .inner_buttons_raw_i   (inner_raw),
    .toggles_raw_i         (tog_raw),
    .rotary_lines_i        (rot_raw),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .enc_button_level_o    (enc_level),
    .button_levels_o       (btn_levels),
    .inner_button_levels_o (inner_levels),
    .toggle_levels_o       (tog_levels),
    .rotary_position_o     (rot_pos),
    .rotary_alarm_o        (rot_fault),
    .rotary_echo_o         (rot_echo)
  );

  always #10 clk_i = ~clk_i;

  // model of the block state
  logic [MsW-1:0]       cfg_debounce;
  logic [MsW-1:0]       cfg_fault_time;
  logic [LineCount-1:0] lvl_stable;
  logic [LineCount-1:0] lvl_cand;
  logic [TimeW-1:0]     lvl_since [LineCount];
  logic [PosW-1:0]      pos_held;
  logic                 rot_bad;
  logic [TimeW-1:0]     rot_bad_since;
  logic                 rot_faulted;

  panel_report_t panel_report_q [$];
  int errors = 0;
  int cycles = 0;
  logic quiet = 1'b0;
  int stall_left = 0;
  int stall_roll;
  panel_report_t want;
  panel_report_t got;

  function automatic void reset_panel_model();
    int k;
    cfg_debounce = DebounceReset;
    cfg_fault_time = RotFaultReset;
    lvl_stable = '0;
    lvl_cand = '0;
    for (k = 0; k < LineCount; k++) lvl_since[k] = '0;
    pos_held = PosInvalid;
    rot_bad = 1'b0;
    rot_bad_since = '0;
    rot_faulted = 1'b0;
  endfunction

  // one poll or seed through the model, returns the report it produces
  function automatic panel_report_t advance_panel(panel_poll_t b);
    logic [LineCount-1:0] raw;
    logic [TimeW-1:0]     elapsed;
    logic                 good;
    int                   k;
    int                   ones;
    int                   first;
    panel_report_t        res;
    raw = {b.tog, b.inner, b.btn, b.enc};
    if (b.req == REQ_SEED) begin
      lvl_stable = raw;
      lvl_cand = raw;
      for (k = 0; k < LineCount; k++) lvl_since[k] = '0;
    end else begin
      for (k = 0; k < LineCount; k++) begin
        elapsed = b.now - lvl_since[k];
        if (lvl_cand[k] != raw[k]) begin
          lvl_cand[k] = raw[k];
          lvl_since[k] = b.now;
        end else if (lvl_stable[k] != raw[k] && elapsed >= {16'h0, cfg_debounce}) begin
          lvl_stable[k] = raw[k];
        end
      end
      ones = 0;
      first = 0;
      good = 1'b0;
      for (k = 0; k < RotW; k++) begin
        if (b.rot[k]) begin
          if (ones == 0) first = k;
          ones++;
        end
      end
      if (ones == 1) begin
        pos_held = PosW'(first);
        good = 1'b1;
      end else if (ones == 2) begin
        for (k = 0; k < RotW - 1; k++) begin
          if (b.rot == (7'b0000011 << k)) good = 1'b1;
        end
      end
      if (good) begin
        rot_bad = 1'b0;
      end else if (!rot_bad) begin
        rot_bad = 1'b1;
        rot_bad_since = b.now;
      end
      elapsed = b.now - rot_bad_since;
      if (rot_bad && elapsed >= {16'h0, cfg_fault_time}) begin
        rot_faulted = 1'b1;
        pos_held = PosInvalid;
      end else if (!rot_bad) begin
        rot_faulted = 1'b0;
      end
    end
    res.enc = lvl_stable[0];
    res.btn = lvl_stable[BtnW:1];
    res.inner = lvl_stable[BtnW+InnerW:BtnW+1];
    res.tog = lvl_stable[LineCount-1:BtnW+InnerW+1];
    res.pos = pos_held;
    res.fault = rot_faulted;
    res.echo = b.rot;
    return res;
  endfunction

  function automatic panel_poll_t make_poll(req_type_e req, logic [TimeW-1:0] now,
                                            logic [LineCount-1:0] lines, logic [RotW-1:0] rot);
    panel_poll_t b;
    b.req = req;
    b.now = now;
    {b.tog, b.inner, b.btn, b.enc} = lines;
    b.rot = rot;
    return b;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_beat(panel_poll_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= b.req;
    now_ms <= b.now;
    enc_raw <= b.enc;
    btn_raw <= b.btn;
    inner_raw <= b.inner;
    tog_raw <= b.tog;
    rot_raw <= b.rot;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    panel_report_q.push_back(advance_panel(b));
  endtask

  task automatic poll(logic [TimeW-1:0] now, logic [LineCount-1:0] lines, logic [RotW-1:0] rot);
    send_beat(make_poll(REQ_POLL, now, lines, rot));
  endtask

  // stop sending and let every result come back before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (panel_report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves cfg_valid high, the caller lowers it after its last write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [MsW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    if (idx == CFG_DEBOUNCE_MS) cfg_debounce = data;
    else if (idx == CFG_ROT_ALARM_MS) cfg_fault_time = data;
  endtask

  task automatic set_timing(logic [MsW-1:0] deb, logic [MsW-1:0] flt);
    drain();
    write_reg(CFG_DEBOUNCE_MS, deb);
    write_reg(CFG_ROT_ALARM_MS, flt);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    poll(32'd0, 15'h0000, 7'h00);
    poll(32'd5, 15'h7fff, 7'h01);
    poll(32'd24, 15'h7fff, 7'h03);
    poll(32'd25, 15'h7fff, 7'h40);
  endtask

  task automatic test_seed_request();
    send_beat(make_poll(REQ_SEED, 32'hffff_ffff, 15'h0000, 7'h7f));
    send_beat(make_poll(REQ_SEED, 32'd0, 15'h7fff, 7'h00));
    poll(32'd0, 15'h0000, 7'h20);
  endtask

  task automatic test_zero_times();
    set_timing(16'd0, 16'd0);
    // non-adjacent pair faults at once, adjacent pair then keeps the position invalid
    poll(32'd100, 15'h5555, 7'h05);
    poll(32'd100, 15'h5555, 7'h0c);
    poll(32'd101, 15'h5555, 7'h08);
  endtask

  task automatic test_extreme_times();
    set_timing(16'hffff, 16'hffff);
    poll(32'd1000, 15'h2aaa, 7'h00);
    poll(32'd1000 + 32'd65534, 15'h2aaa, 7'h7f);
    poll(32'd1000 + 32'd65535, 15'h2aaa, 7'h7f);
  endtask

  task automatic test_time_wrap();
    set_timing(DebounceReset, RotFaultReset);
    poll(32'hffff_fff8, 15'h0000, 7'h02);
    poll(32'h0000_000b, 15'h0000, 7'h02);
    poll(32'h0000_000c, 15'h0000, 7'h10);
  endtask

  task automatic test_spare_index();
    drain();
    write_reg(CfgSpareLo, 16'hffff);
    write_reg(CfgSpareHi, 16'h0000);
    cfg_valid <= 1'b0;
    poll(32'h20, 15'h7fff, 7'h01);
    poll(32'h34, 15'h7fff, 7'h01);
    // bounce back before the dwell ends
    poll(32'h40, 15'h0000, 7'h01);
    poll(32'h48, 15'h7fff, 7'h06);
    poll(32'h60, 15'h7fff, 7'h06);
  endtask

  task automatic test_random_traffic(int n, logic [MsW-1:0] deb, logic [MsW-1:0] flt,
                                     logic [TimeW-1:0] t0);
    logic [TimeW-1:0]     t;
    logic [LineCount-1:0] target;
    logic [LineCount-1:0] lines;
    logic [RotW-1:0]      rot;
    logic [3:0]           flip;
    req_type_e            req;
    int                   pos;
    int                   bad_left;
    int                   i;
    int                   c;
    set_timing(deb, flt);
    t = t0;
    target = LineCount'($urandom());
    pos = $urandom_range(0, RotW - 1);
    bad_left = 0;
    for (i = 0; i < n; i++) begin
      if (i % 25 == 0) quiet = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 3) t = $urandom();
      else t = t + $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) begin
        flip = 4'($urandom_range(0, LineCount - 1));
        target[flip] ^= 1'b1;
      end
      lines = target;
      if ($urandom_range(0, 6) == 0) begin
        flip = 4'($urandom_range(0, LineCount - 1));
        lines[flip] ^= 1'b1;
      end
      if ($urandom_range(0, 49) == 0) lines = LineCount'($urandom());
      if (bad_left > 0) begin
        rot = RotW'($urandom());
        bad_left--;
      end else begin
        if ($urandom_range(0, 32) == 0) bad_left = $urandom_range(3, 60);
        c = $urandom_range(0, 99);
        if (c < 5) pos = (pos == 0) ? 1 : (pos == RotW - 1) ? pos - 1 :
                         pos + ($urandom_range(0, 1) ? 1 : -1);
        if (c < 75) rot = RotW'(1) << pos;
        else if (c < 88) rot = (pos < RotW - 1) ? (RotW'(3) << pos) : (RotW'(3) << (pos - 1));
        else if (c < 94) rot = '0;
        else rot = RotW'($urandom());
      end
      req = ($urandom_range(0, 49) == 0) ? REQ_SEED : REQ_POLL;
      send_beat(make_poll(req, t, lines, rot));
    end
    quiet = 1'b0;
  endtask

  // receiver side backpressure, mostly short stalls with a few long ones
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 65) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 96) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // every result beat is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (panel_report_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing predicted", $time);
      end else begin
        want = panel_report_q.pop_front();
        got = '{enc_level, btn_levels, inner_levels, tog_levels, rot_pos, rot_fault, rot_echo};
        report_field("enc_button_level", 32'(want.enc), 32'(got.enc));
        report_field("button_levels", 32'(want.btn), 32'(got.btn));
        report_field("inner_button_levels", 32'(want.inner), 32'(got.inner));
        report_field("toggle_levels", 32'(want.tog), 32'(got.tog));
        report_field("rotary_position", 32'(want.pos), 32'(got.pos));
        report_field("rotary_alarm", 32'(want.fault), 32'(got.fault));
        report_field("rotary_echo", 32'(want.echo), 32'(got.echo));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    reset_panel_model();
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_seed_request();
    test_zero_times();
    test_extreme_times();
    test_time_wrap();
    test_spare_index();
    test_random_traffic(100, DebounceReset, RotFaultReset, $urandom());
    test_random_traffic(100, 16'd0, 16'd0, 32'hffff_fe00);
    test_random_traffic(100, 16'hffff, 16'hffff, $urandom());
    test_random_traffic(100, MsW'($urandom_range(0, 40)), MsW'($urandom_range(0, 200)),
                        $urandom());
    test_random_traffic(100, 16'd5, 16'd30, 32'hffff_ff80);
    test_random_traffic(100, MsW'($urandom()), MsW'($urandom()), $urandom());
    drain();
    if (errors == 0 && panel_report_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
